@@ rtl/segment_circle_penetration_defines.svh @@
// Assertion macros used by the RTL of the segment/circle penetration block.
`ifndef SEGMENT_CIRCLE_PENETRATION_DEFINES_SVH
`define SEGMENT_CIRCLE_PENETRATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Fixed-delay implication, disabled while reset is asserted.
`define SCP_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("latency check failed");

`endif

@@ rtl/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

	// Default coordinate width (signed Q11.4 at 16 bits)
	localparam int COORD_WIDTH_DEF = 16;

	// Which point of the segment is closest to the circle centre
	typedef enum logic [1:0] {
		SEL_A   = 2'd0,
		SEL_B   = 2'd1,
		SEL_MID = 2'd2
	} csel_t;

endpackage

@@ rtl/segment_circle_penetration.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Most of the pipeline depth lies in the three bit-per-stage units: projection divide, square root, push divide.
// done strobes for one cycle with hit/offset_x/offset_y; the receiver cannot stall.
// Reset: arst_n clears every valid bit and hit at once; the other payload registers are not reset.
`include "segment_circle_penetration_defines.svh"

module segment_circle_penetration #(
	parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] seg_a_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_y,
	input  logic signed [COORD_WIDTH-1:0] circle_x,
	input  logic signed [COORD_WIDTH-1:0] circle_y,
	input  logic        [COORD_WIDTH-2:0] radius,
	output logic                          done,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] offset_x,
	output logic signed [COORD_WIDTH-1:0] offset_y
);

	localparam int W   = COORD_WIDTH;
	localparam int LAT = 3 * W + 11;

	// Sideband carried through the projection dividers
	typedef struct packed {
		scp_pkg::csel_t sel;
		logic           neg;
		logic [W-1:0]   a;
		logic [W-1:0]   b;
		logic [W-1:0]   p;
		logic [W-2:0]   r;
	} prj_x_side_t;

	typedef struct packed {
		logic         neg;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] p;
	} prj_y_side_t;

	// Sideband carried through the square root
	typedef struct packed {
		logic         negx;
		logic         negy;
		logic [W:0]   mx;
		logic [W:0]   my;
		logic [W-2:0] r;
	} rt_side_t;

	typedef struct packed {
		logic hit;
		logic neg;
	} push_x_side_t;

	// The pipeline always advances, so a beat is taken every cycle.
	assign busy = 1'b0;

	// ---------------- Stage 1: capture, S = B - A, V = P - A ----------------
	logic                v_s1;
	logic signed [W:0]   sx_s1, sy_s1, vx_s1, vy_s1;
	logic [W-1:0]        ax_s1, ay_s1, bx_s1, by_s1, px_s1, py_s1;
	logic [W-2:0]        r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= {seg_b_x[W-1], seg_b_x} - {seg_a_x[W-1], seg_a_x};
		sy_s1 <= {seg_b_y[W-1], seg_b_y} - {seg_a_y[W-1], seg_a_y};
		vx_s1 <= {circle_x[W-1], circle_x} - {seg_a_x[W-1], seg_a_x};
		vy_s1 <= {circle_y[W-1], circle_y} - {seg_a_y[W-1], seg_a_y};
		ax_s1 <= seg_a_x;
		ay_s1 <= seg_a_y;
		bx_s1 <= seg_b_x;
		by_s1 <= seg_b_y;
		px_s1 <= circle_x;
		py_s1 <= circle_y;
		r_s1  <= radius;
	end

	// ---------------- Stage 2: squares of |S| and the dot terms ----------------
	logic [W:0]   nsx, nsy;
	logic [W-1:0] msx, msy;

	always_comb begin
		nsx = -sx_s1;
		nsy = -sy_s1;
		msx = sx_s1[W] ? nsx[W-1:0] : sx_s1[W-1:0];
		msy = sy_s1[W] ? nsy[W-1:0] : sy_s1[W-1:0];
	end

	logic                  v_s2;
	logic [2*W-1:0]        ssx_s2, ssy_s2;
	logic signed [2*W+1:0] tvx_s2, tvy_s2;
	logic [W-1:0]          msx_s2, msy_s2;
	logic                  negx_s2, negy_s2;
	logic [W-1:0]          ax_s2, ay_s2, bx_s2, by_s2, px_s2, py_s2;
	logic [W-2:0]          r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ssx_s2  <= msx * msx;
		ssy_s2  <= msy * msy;
		tvx_s2  <= sx_s1 * vx_s1;
		tvy_s2  <= sy_s1 * vy_s1;
		msx_s2  <= msx;
		msy_s2  <= msy;
		negx_s2 <= sx_s1[W];
		negy_s2 <= sy_s1[W];
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		bx_s2   <= bx_s1;
		by_s2   <= by_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		r_s2    <= r_s1;
	end

	// ---------------- Stage 3: L2 = S.S, T = V.S ----------------
	logic                  v_s3;
	logic [2*W:0]          l2_s3;
	logic signed [2*W+2:0] t_s3;
	logic [W-1:0]          msx_s3, msy_s3;
	logic                  negx_s3, negy_s3;
	logic [W-1:0]          ax_s3, ay_s3, bx_s3, by_s3, px_s3, py_s3;
	logic [W-2:0]          r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		l2_s3   <= {1'b0, ssx_s2} + {1'b0, ssy_s2};
		t_s3    <= {tvx_s2[2*W+1], tvx_s2} + {tvy_s2[2*W+1], tvy_s2};
		msx_s3  <= msx_s2;
		msy_s3  <= msy_s2;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
		bx_s3   <= bx_s2;
		by_s3   <= by_s2;
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		r_s3    <= r_s2;
	end

	// ---------------- Stage 4: clamp decision, |S| * T ----------------
	// A zero-length segment or a projection behind A picks A; past B picks B.
	scp_pkg::csel_t sel_n;

	always_comb begin
		if (l2_s3 == '0 || t_s3[2*W+2] || t_s3 == '0) begin
			sel_n = scp_pkg::SEL_A;
		end else if (t_s3[2*W+1:0] >= {1'b0, l2_s3}) begin
			sel_n = scp_pkg::SEL_B;
		end else begin
			sel_n = scp_pkg::SEL_MID;
		end
	end

	logic           v_s4;
	logic [3*W:0]   pmx_s4, pmy_s4;
	logic [2*W:0]   l2_s4;
	prj_x_side_t    sdx_s4;
	prj_y_side_t    sdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pmx_s4     <= msx_s3 * t_s3[2*W:0];
		pmy_s4     <= msy_s3 * t_s3[2*W:0];
		l2_s4      <= l2_s3;
		sdx_s4.sel <= sel_n;
		sdx_s4.neg <= negx_s3;
		sdx_s4.a   <= ax_s3;
		sdx_s4.b   <= bx_s3;
		sdx_s4.p   <= px_s3;
		sdx_s4.r   <= r_s3;
		sdy_s4.neg <= negy_s3;
		sdy_s4.a   <= ay_s3;
		sdy_s4.b   <= by_s3;
		sdy_s4.p   <= py_s3;
	end

	// ---------------- Projection divide: |S| * T / L2 per axis ----------------
	logic        dvx_v, dvy_v;
	logic [W-1:0] qx, qy;
	prj_x_side_t dvx_sd;
	prj_y_side_t dvy_sd;

	scp_div #(
		.NW (3*W+1),
		.DW (2*W+1),
		.QW (W),
		.SW ($bits(prj_x_side_t))
	) u_div_px (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (pmx_s4),
		.den       (l2_s4),
		.side_in   (sdx_s4),
		.out_valid (dvx_v),
		.quo       (qx),
		.side_out  (dvx_sd)
	);

	scp_div #(
		.NW (3*W+1),
		.DW (2*W+1),
		.QW (W),
		.SW ($bits(prj_y_side_t))
	) u_div_py (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (pmy_s4),
		.den       (l2_s4),
		.side_in   (sdy_s4),
		.out_valid (dvy_v),
		.quo       (qy),
		.side_out  (dvy_sd)
	);

	// ---------------- Stage 5: closest point C, D = P - C ----------------
	logic signed [W:0] cx, cy;

	always_comb begin
		case (dvx_sd.sel)
			scp_pkg::SEL_B: begin
				cx = {dvx_sd.b[W-1], dvx_sd.b};
				cy = {dvy_sd.b[W-1], dvy_sd.b};
			end
			scp_pkg::SEL_MID: begin
				cx = dvx_sd.neg ? {dvx_sd.a[W-1], dvx_sd.a} - {1'b0, qx}
					: {dvx_sd.a[W-1], dvx_sd.a} + {1'b0, qx};
				cy = dvy_sd.neg ? {dvy_sd.a[W-1], dvy_sd.a} - {1'b0, qy}
					: {dvy_sd.a[W-1], dvy_sd.a} + {1'b0, qy};
			end
			default: begin
				cx = {dvx_sd.a[W-1], dvx_sd.a};
				cy = {dvy_sd.a[W-1], dvy_sd.a};
			end
		endcase
	end

	logic              v_s5;
	logic signed [W:0] dx_s5, dy_s5;
	logic [W-2:0]      r_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= dvx_v && dvy_v;
		end
	end

	always_ff @(posedge clk) begin
		dx_s5 <= {dvx_sd.p[W-1], dvx_sd.p} - cx;
		dy_s5 <= {dvy_sd.p[W-1], dvy_sd.p} - cy;
		r_s5  <= dvx_sd.r;
	end

	// ---------------- Stage 6: squares of |D| ----------------
	logic [W:0] ndx, ndy, mdx, mdy;

	always_comb begin
		ndx = -dx_s5;
		ndy = -dy_s5;
		mdx = dx_s5[W] ? ndx : dx_s5;
		mdy = dy_s5[W] ? ndy : dy_s5;
	end

	logic           v_s6;
	logic [2*W+1:0] sqx_s6, sqy_s6;
	rt_side_t       rs_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s6     <= mdx * mdx;
		sqy_s6     <= mdy * mdy;
		rs_s6.negx <= dx_s5[W];
		rs_s6.negy <= dy_s5[W];
		rs_s6.mx   <= mdx;
		rs_s6.my   <= mdy;
		rs_s6.r    <= r_s5;
	end

	// ---------------- Stage 7: |D|^2 ----------------
	logic         v_s7;
	logic [2*W+2:0] d2_s7;
	rt_side_t     rs_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		d2_s7 <= {1'b0, sqx_s6} + {1'b0, sqy_s6};
		rs_s7 <= rs_s6;
	end

	// ---------------- Distance d = isqrt(|D|^2) ----------------
	logic         rt_v;
	logic [W+1:0] dlen;
	rt_side_t     rt_sd;

	scp_sqrt #(
		.NW (2*W+3),
		.SW ($bits(rt_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.rad       (d2_s7),
		.side_in   (rs_s7),
		.out_valid (rt_v),
		.root      (dlen),
		.side_out  (rt_sd)
	);

	// ---------------- Stage 8: hit test, r - d ----------------
	// Centre on the segment (d = 0) and centre beyond the radius both miss.
	logic hit_n;

	assign hit_n = (dlen != '0) && (dlen <= {3'b000, rt_sd.r});

	logic         v_s8, hit_s8, negx_s8, negy_s8;
	logic [W-2:0] rd_s8, den_s8;
	logic [W:0]   mx_s8, my_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		hit_s8  <= hit_n;
		rd_s8   <= hit_n ? rt_sd.r - dlen[W-2:0] : '0;
		// On a miss divide by one so the divider sees a harmless operand
		den_s8  <= hit_n ? dlen[W-2:0] : {{(W-2){1'b0}}, 1'b1};
		negx_s8 <= rt_sd.negx;
		negy_s8 <= rt_sd.negy;
		mx_s8   <= rt_sd.mx;
		my_s8   <= rt_sd.my;
	end

	// ---------------- Stage 9: |D| * (r - d) ----------------
	logic         v_s9;
	logic [2*W-1:0] nmx_s9, nmy_s9;
	logic [W-2:0] den_s9;
	push_x_side_t psx_s9;
	logic         negy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		nmx_s9     <= mx_s8 * rd_s8;
		nmy_s9     <= my_s8 * rd_s8;
		den_s9     <= den_s8;
		psx_s9.hit <= hit_s8;
		psx_s9.neg <= negx_s8;
		negy_s9    <= negy_s8;
	end

	// ---------------- Push divide: |D| * (r - d) / d per axis ----------------
	logic         pvx, pvy, pneg_y;
	logic [W-2:0] ox, oy;
	push_x_side_t psx_o;

	scp_div #(
		.NW (2*W),
		.DW (W-1),
		.QW (W-1),
		.SW ($bits(push_x_side_t))
	) u_div_ox (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.num       (nmx_s9),
		.den       (den_s9),
		.side_in   (psx_s9),
		.out_valid (pvx),
		.quo       (ox),
		.side_out  (psx_o)
	);

	scp_div #(
		.NW (2*W),
		.DW (W-1),
		.QW (W-1),
		.SW (1)
	) u_div_oy (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.num       (nmy_s9),
		.den       (den_s9),
		.side_in   (negy_s9),
		.out_valid (pvy),
		.quo       (oy),
		.side_out  (pneg_y)
	);

	// ---------------- Output register: sign and strobe ----------------
	logic [W-1:0] ox_w, oy_w;

	always_comb begin
		ox_w = {1'b0, ox};
		oy_w = {1'b0, oy};
		if (psx_o.neg) begin
			ox_w = -ox_w;
		end
		if (pneg_y) begin
			oy_w = -oy_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			hit  <= 1'b0;
		end else begin
			done <= pvx && pvy;
			hit  <= pvx && pvy && psx_o.hit;
		end
	end

	// Zero the offset on a miss
	always_ff @(posedge clk) begin
		offset_x <= psx_o.hit ? ox_w : '0;
		offset_y <= psx_o.hit ? oy_w : '0;
	end

	// ---------------- Checks ----------------
	`SCP_ASSERT_DLY(a_latency, clk, arst_n, start && !busy, LAT, done)
	`SCP_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !hit, offset_x == '0 && offset_y == '0)
	`SCP_ASSERT_IMP(a_hit_strobe, clk, arst_n, !done, !hit)

endmodule

@@ rtl/scp_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage.
module scp_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [CW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic          vld_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic [CW-1:0] rem_p, rem_n, dsh;
		logic [DW-1:0] den_p;
		logic [QW-1:0] quo_p, quo_n;
		logic [SW-1:0] side_p;
		logic          vld_p;
		logic [CW:0]   diff;

		if (k == 0) begin : g_in
			assign rem_p  = {{(CW-NW){1'b0}}, num};
			assign den_p  = den;
			assign quo_p  = '0;
			assign side_p = side_in;
			assign vld_p  = in_valid;
		end else begin : g_mid
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		// Trial subtract of the divisor aligned to this quotient bit
		always_comb begin
			dsh   = {{(CW-DW){1'b0}}, den_p} << SH;
			diff  = {1'b0, rem_p} - {1'b0, dsh};
			rem_n = diff[CW] ? rem_p : diff[CW-1:0];
			quo_n = quo_p;
			if (!diff[CW]) begin
				quo_n[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_n;
			den_s[k]  <= den_p;
			quo_s[k]  <= quo_n;
			side_s[k] <= side_p;
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

@@ rtl/scp_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, truncating: one root bit per stage.
module scp_sqrt #(
	parameter int NW = 32,
	parameter int SW = 1,
	localparam int RW = (NW + 1) / 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] rad,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [RW-1:0] root,
	output logic [SW-1:0] side_out
);

	localparam int PW = 2 * RW;

	logic [PW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [SW-1:0] side_s [RW];
	logic          vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int SH = RW - 1 - k;
		logic [PW-1:0] rem_p, rem_n;
		logic [RW-1:0] root_p, root_n;
		logic [SW-1:0] side_p;
		logic          vld_p;
		logic [PW:0]   trial;

		if (k == 0) begin : g_in
			assign rem_p  = {{(PW-NW){1'b0}}, rad};
			assign root_p = '0;
			assign side_p = side_in;
			assign vld_p  = in_valid;
		end else begin : g_mid
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		// (root + 2^SH)^2 - root^2 = root * 2^(SH+1) + 2^(2*SH)
		always_comb begin
			trial  = ({{(PW+1-RW){1'b0}}, root_p} << (SH + 1))
				+ ({{PW{1'b0}}, 1'b1} << (2 * SH));
			rem_n  = rem_p;
			root_n = root_p;
			if ({1'b0, rem_p} >= trial) begin
				rem_n       = rem_p - trial[PW-1:0];
				root_n[SH]  = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_n;
			root_s[k] <= root_n;
			side_s[k] <= side_p;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule
